>>> sv/msps_pkg.sv
// Shared types and constants for the multi-sonar ping scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package msps_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDTRIP = 2'd3;

    localparam logic [15:0] PERIOD_RST    = 16'd50;
    localparam logic [5:0]  MISS_THR_RST  = 6'd3;
    localparam logic [15:0] MAX_DIST_RST  = 16'd5000;
    localparam logic [7:0]  ROUNDTRIP_RST = 8'd57;

    localparam logic [31:0] START_DELAY_MS = 32'd100;
    localparam logic [19:0] MM_PER_CM      = 20'd10;
    localparam logic [2:0]  MAX_PINGS      = 3'd4;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ECHO  = 2'd2,
        CMD_QUERY = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        KIND_PING  = 2'd0,
        KIND_ECHO  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_INIT,
        ST_START_DONE,
        ST_TICK_SCAN,
        ST_ECHO_WAIT,
        ST_ECHO_UPD,
        ST_ECHO_OUT,
        ST_QUERY_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  idx_inc;
        logic  init_due;
        logic  clr_miss;
        logic  tick_upd;
        logic  div_start;
        logic  echo_upd;
        logic  emit;
        t_kind emit_kind;
        logic  emit_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic due_here;
        logic more_due;
        logic idx_last;
        logic div_done;
        logic slot_free;
    } t_dp_stat;

endpackage

>>> sv/msps_div.sv
// Restoring divider for the echo conversion, two quotient bits per cycle.
// Standalone; uses no package items.
module msps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [19:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_done,
    output logic [15:0] o_quotient
);

    localparam int DIV_STEPS = 10;

    logic [19:0] r_dq;
    logic [7:0]  r_rem;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [8:0]  t1, t2;
    logic        ge1, ge2;
    logic [7:0]  rem1, rem2;
    logic [19:0] dq1, dq2;

    // The dividend shifts out of the top of r_dq while quotient bits enter at the bottom.
    always_comb begin
        t1   = {r_rem, r_dq[19]};
        ge1  = (t1 >= {1'b0, i_divisor});
        rem1 = ge1 ? 8'(t1 - {1'b0, i_divisor}) : t1[7:0];
        dq1  = {r_dq[18:0], ge1};
        t2   = {rem1, dq1[19]};
        ge2  = (t2 >= {1'b0, i_divisor});
        rem2 = ge2 ? 8'(t2 - {1'b0, i_divisor}) : t2[7:0];
        dq2  = {dq1[18:0], ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dq  <= dq2;
            r_rem <= rem2;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = (|r_dq[19:16]) ? 16'hFFFF : r_dq[15:0];

endmodule

>>> sv/msps_dp.sv
// Datapath of the ping scheduler: configuration, per-sensor state, divider and
// output register. Depends on msps_pkg and msps_div.
module msps_dp #(
    parameter int NUM_SENSORS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  msps_pkg::t_dp_cmd              i_cmd,
    output msps_pkg::t_dp_stat             o_stat,
    input  logic                           i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [msps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]                    i_now_ms,
    input  logic                           i_echo_received,
    input  logic [15:0]                    i_echo_time_us,
    input  logic [1:0]                     i_sensor_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_kind,
    output logic [1:0]                     o_sensor,
    output logic [1:0]                     o_stopped_sensor,
    output logic [15:0]                    o_distance_mm,
    output logic                           o_too_far,
    output logic                           o_last
);

    localparam int IW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    logic [15:0] r_period;
    logic [5:0]  r_miss_thr;
    logic [15:0] r_max_dist;
    logic [7:0]  r_roundtrip;

    logic [31:0] r_due     [NUM_SENSORS];
    logic [15:0] r_reading [NUM_SENSORS];
    logic [7:0]  r_miss    [NUM_SENSORS];
    logic [IW-1:0] r_cur;

    logic [IW-1:0]          r_idx;
    logic [31:0]            r_acc;
    logic [31:0]            r_step;
    logic [NUM_SENSORS-1:0] r_due_mask;
    logic                   r_echo;
    logic [1:0]             r_qidx;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [1:0]  r_sensor;
    logic [1:0]  r_stopped;
    logic [15:0] r_dist;
    logic        r_far;
    logic        r_last;

    logic [NUM_SENSORS-1:0] n_due_mask;
    logic [NUM_SENSORS-1:0] higher_due;
    logic [IW-1:0]          rd_addr;
    logic [15:0]            rd_reading;
    logic                   rd_far;
    logic                   q_in_range;
    logic [7:0]             m_inc;
    logic                   m_reach;
    logic                   m_fold;
    logic                   slot_free;
    logic                   div_done;
    logic [15:0]            div_quot;

    msps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (20'(i_echo_time_us) * msps_pkg::MM_PER_CM),
        .i_divisor  (r_roundtrip),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= msps_pkg::PERIOD_RST;
            r_miss_thr  <= msps_pkg::MISS_THR_RST;
            r_max_dist  <= msps_pkg::MAX_DIST_RST;
            r_roundtrip <= msps_pkg::ROUNDTRIP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                msps_pkg::REG_PERIOD:    r_period    <= i_cfg_data[15:0];
                msps_pkg::REG_MISS_THR:  r_miss_thr  <= i_cfg_data[5:0];
                msps_pkg::REG_MAX_DIST:  r_max_dist  <= i_cfg_data[15:0];
                msps_pkg::REG_ROUNDTRIP: r_roundtrip <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sensors due at this tick are decided all at once when the word is taken.
    always_comb begin
        for (int j = 0; j < NUM_SENSORS; j++) begin
            n_due_mask[j] = (i_now_ms >= r_due[j]);
            higher_due[j] = r_due_mask[j] && (j > int'(r_idx));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx      <= '0;
            r_acc      <= i_now_ms + msps_pkg::START_DELAY_MS;
            r_step     <= 32'(r_period) * 32'(NUM_SENSORS);
            r_due_mask <= n_due_mask;
            r_echo     <= i_echo_received;
            r_qidx     <= i_sensor_index;
        end else begin
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.init_due) begin
                r_acc <= r_acc + 32'(r_period);
            end
        end
    end

    always_comb begin
        case (i_cmd.emit_kind)
            msps_pkg::KIND_ECHO:  rd_addr = r_cur;
            msps_pkg::KIND_QUERY: rd_addr = IW'(r_qidx);
            default:              rd_addr = r_idx;
        endcase
        rd_reading = r_reading[rd_addr];
        rd_far     = (r_miss[rd_addr] >= {2'b00, r_miss_thr});
        q_in_range = (32'(r_qidx) < NUM_SENSORS);
    end

    // A missed echo: the counter saturates into the too-far band and folds back
    // to the threshold once it passes twice the threshold.
    always_comb begin
        m_inc   = r_miss[r_cur] + 8'd1;
        m_reach = (m_inc >= {2'b00, r_miss_thr});
        m_fold  = (m_inc > {1'b0, r_miss_thr, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_SENSORS; j++) begin
                r_due[j]     <= '0;
                r_reading[j] <= '0;
                r_miss[j]    <= '0;
            end
            r_cur <= '0;
        end else begin
            if (i_cmd.init_due) begin
                r_due[r_idx] <= r_acc;
            end
            if (i_cmd.tick_upd) begin
                r_due[r_idx] <= r_due[r_idx] + r_step;
                r_cur        <= r_idx;
            end
            if (i_cmd.clr_miss) begin
                for (int j = 0; j < NUM_SENSORS; j++) begin
                    r_miss[j] <= '0;
                end
            end
            if (i_cmd.echo_upd) begin
                if (r_echo) begin
                    r_reading[r_cur] <= div_quot;
                    r_miss[r_cur]    <= '0;
                end else begin
                    if (m_reach) begin
                        r_reading[r_cur] <= r_max_dist;
                    end
                    r_miss[r_cur] <= m_fold ? 8'(r_miss_thr) : m_inc;
                end
            end
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= i_cmd.emit_kind;
            r_last <= i_cmd.emit_last;
            case (i_cmd.emit_kind)
                msps_pkg::KIND_PING: begin
                    r_sensor  <= 2'(r_idx);
                    r_stopped <= 2'(r_cur);
                    r_dist    <= rd_reading;
                    r_far     <= rd_far;
                end
                msps_pkg::KIND_ECHO: begin
                    r_sensor  <= 2'(r_cur);
                    r_stopped <= '0;
                    r_dist    <= rd_reading;
                    r_far     <= rd_far;
                end
                msps_pkg::KIND_QUERY: begin
                    r_sensor  <= r_qidx;
                    r_stopped <= '0;
                    r_dist    <= q_in_range ? rd_reading : '0;
                    r_far     <= q_in_range && rd_far;
                end
                default: begin
                    r_sensor  <= '0;
                    r_stopped <= '0;
                    r_dist    <= '0;
                    r_far     <= 1'b0;
                end
            endcase
        end
    end

    assign o_stat.due_here  = r_due_mask[r_idx];
    assign o_stat.more_due  = |higher_due;
    assign o_stat.idx_last  = (r_idx == IW'(NUM_SENSORS - 1));
    assign o_stat.div_done  = div_done;
    assign o_stat.slot_free = slot_free;

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_sensor         = r_sensor;
    assign o_stopped_sensor = r_stopped;
    assign o_distance_mm    = r_dist;
    assign o_too_far        = r_far;
    assign o_last           = r_last;

endmodule

>>> sv/msps_ctrl.sv
// Controller of the ping scheduler: sequences each command over the datapath.
// Depends on msps_pkg.
module msps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_command,
    input  msps_pkg::t_dp_stat  i_stat,
    output msps_pkg::t_dp_cmd   o_cmd
);

    msps_pkg::t_state r_state, n_state;
    logic [2:0]       r_sent, n_sent;
    logic             accept;
    logic             can_emit;
    logic             tick_go;

    assign o_in_ready = (r_state == msps_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign can_emit   = (r_sent < msps_pkg::MAX_PINGS);
    // A due sensor that still gets a ping word must wait for the output slot.
    assign tick_go    = !i_stat.due_here || !can_emit || i_stat.slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            msps_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_command)
                        msps_pkg::CMD_START: n_state = msps_pkg::ST_START_INIT;
                        msps_pkg::CMD_TICK:  n_state = msps_pkg::ST_TICK_SCAN;
                        msps_pkg::CMD_ECHO:  n_state = msps_pkg::ST_ECHO_WAIT;
                        default:             n_state = msps_pkg::ST_QUERY_OUT;
                    endcase
                end
            end
            msps_pkg::ST_START_INIT: begin
                if (i_stat.idx_last) n_state = msps_pkg::ST_START_DONE;
            end
            msps_pkg::ST_START_DONE: begin
                if (i_stat.slot_free) n_state = msps_pkg::ST_IDLE;
            end
            msps_pkg::ST_TICK_SCAN: begin
                if (tick_go && i_stat.idx_last) n_state = msps_pkg::ST_IDLE;
            end
            msps_pkg::ST_ECHO_WAIT: begin
                if (i_stat.div_done) n_state = msps_pkg::ST_ECHO_UPD;
            end
            msps_pkg::ST_ECHO_UPD: begin
                n_state = msps_pkg::ST_ECHO_OUT;
            end
            msps_pkg::ST_ECHO_OUT, msps_pkg::ST_QUERY_OUT: begin
                if (i_stat.slot_free) n_state = msps_pkg::ST_IDLE;
            end
            default: n_state = msps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_kind = msps_pkg::KIND_PING;
        case (r_state)
            msps_pkg::ST_IDLE: begin
                o_cmd.load      = accept;
                o_cmd.div_start = accept && (i_command == msps_pkg::CMD_ECHO);
            end
            msps_pkg::ST_START_INIT: begin
                o_cmd.init_due = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            msps_pkg::ST_START_DONE: begin
                o_cmd.clr_miss  = i_stat.slot_free;
                o_cmd.emit      = i_stat.slot_free;
                o_cmd.emit_kind = msps_pkg::KIND_DONE;
                o_cmd.emit_last = 1'b1;
            end
            msps_pkg::ST_TICK_SCAN: begin
                o_cmd.idx_inc   = tick_go;
                o_cmd.tick_upd  = tick_go && i_stat.due_here;
                o_cmd.emit      = tick_go && i_stat.due_here && can_emit;
                o_cmd.emit_kind = msps_pkg::KIND_PING;
                o_cmd.emit_last = (r_sent == msps_pkg::MAX_PINGS - 3'd1) || !i_stat.more_due;
            end
            msps_pkg::ST_ECHO_UPD: begin
                o_cmd.echo_upd = 1'b1;
            end
            msps_pkg::ST_ECHO_OUT: begin
                o_cmd.emit      = i_stat.slot_free;
                o_cmd.emit_kind = msps_pkg::KIND_ECHO;
                o_cmd.emit_last = 1'b1;
            end
            msps_pkg::ST_QUERY_OUT: begin
                o_cmd.emit      = i_stat.slot_free;
                o_cmd.emit_kind = msps_pkg::KIND_QUERY;
                o_cmd.emit_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_sent = r_sent;
        if (o_cmd.load) begin
            n_sent = '0;
        end else if (o_cmd.emit && (r_state == msps_pkg::ST_TICK_SCAN)) begin
            n_sent = r_sent + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msps_pkg::ST_IDLE;
            r_sent  <= '0;
        end else begin
            r_state <= n_state;
            r_sent  <= n_sent;
        end
    end

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.slot_free)
        else $error("result word issued while the output register is occupied");

    a_ping_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && r_state == msps_pkg::ST_TICK_SCAN) |-> (r_sent < msps_pkg::MAX_PINGS))
        else $error("more ping words issued for one tick than allowed");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msps_pkg::ST_ECHO_WAIT && i_stat.div_done)
        |=> (r_state == msps_pkg::ST_ECHO_UPD))
        else $error("divider finished but the echo update did not follow");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input taken again before the previous command was worked");

endmodule

>>> sv/multi_sonar_ping_scheduler_top.sv
// Top level of the multi-sonar ping scheduler.
// Depends on msps_pkg, msps_ctrl and msps_dp.

// One command word is worked at a time and the input is ready only when the
// previous word has been fully handled; a finished result may still sit in the
// output register while the next word is taken. Start writes one due time per
// cycle through a single adder and then issues a done word; tick visits one
// sensor per cycle through the due-time adder; echo runs the divider, which
// produces two quotient bits per cycle, then updates the sensor and issues the
// result; query issues its result directly. Each result word may hold its
// command back while the output register is still held by the consumer. A
// tick reports at most four ping-start words; later due sensors are still
// rescheduled.
module multi_sonar_ping_scheduler_top #(
    parameter int NUM_SENSORS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_command,
    input  logic [31:0]                     i_now_ms,
    input  logic                            i_echo_received,
    input  logic [15:0]                     i_echo_time_us,
    input  logic [1:0]                      i_sensor_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_kind,
    output logic [1:0]                      o_sensor,
    output logic [1:0]                      o_stopped_sensor,
    output logic [15:0]                     o_distance_mm,
    output logic                            o_too_far,
    output logic                            o_last
);

    msps_pkg::t_dp_cmd  dp_cmd;
    msps_pkg::t_dp_stat dp_stat;

    msps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    msps_dp #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_now_ms         (i_now_ms),
        .i_echo_received  (i_echo_received),
        .i_echo_time_us   (i_echo_time_us),
        .i_sensor_index   (i_sensor_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_sensor         (o_sensor),
        .o_stopped_sensor (o_stopped_sensor),
        .o_distance_mm    (o_distance_mm),
        .o_too_far        (o_too_far),
        .o_last           (o_last)
    );

endmodule

>>> tb/sv/multi_sonar_ping_scheduler_top_tb.sv
// Self-checking testbench for multi_sonar_ping_scheduler_top: a queue-fed driver, an
// output monitor and an in-bench predictor of the schedule, readings and miss counts.
// Depends on msps_pkg and the scheduler RTL only.
module multi_sonar_ping_scheduler_top_tb;

    localparam int SENSORS       = 4;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        msps_pkg::t_command cmd;
        logic [31:0]        now;
        logic               echo;
        logic [15:0]        echo_us;
        logic [1:0]         idx;
    } t_cmd_word;

    typedef struct packed {
        msps_pkg::t_kind kind;
        logic [1:0]      sensor;
        logic [1:0]      stopped;
        logic [15:0]     dist_mm;
        logic            far;
        logic            fin;
    } t_report;

    logic        i_clk;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [msps_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [msps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [1:0]  cmd_drv  = '0;
    logic [31:0] now_drv  = '0;
    logic        echo_drv = 1'b0;
    logic [15:0] us_drv   = '0;
    logic [1:0]  idx_drv  = '0;
    logic        out_ready = 1'b0;

    logic        o_in_ready, o_out_valid, o_too_far, o_last;
    logic [1:0]  o_kind, o_sensor, o_stopped_sensor;
    logic [15:0] o_distance_mm;

    multi_sonar_ping_scheduler_top #(.NUM_SENSORS(SENSORS)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (cmd_drv),
        .i_now_ms        (now_drv),
        .i_echo_received (echo_drv),
        .i_echo_time_us  (us_drv),
        .i_sensor_index  (idx_drv),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (o_kind),
        .o_sensor        (o_sensor),
        .o_stopped_sensor(o_stopped_sensor),
        .o_distance_mm   (o_distance_mm),
        .o_too_far       (o_too_far),
        .o_last          (o_last)
    );

    // Predictor state and its copy of the registers.
    logic [31:0] due_q   [SENSORS];
    logic [15:0] range_q [SENSORS];
    logic [7:0]  miss_q  [SENSORS];
    logic [1:0]  cur_q;
    logic [15:0] period_cfg = msps_pkg::PERIOD_RST;
    logic [5:0]  thr_cfg    = msps_pkg::MISS_THR_RST;
    logic [15:0] maxd_cfg   = msps_pkg::MAX_DIST_RST;
    logic [7:0]  rt_cfg     = msps_pkg::ROUNDTRIP_RST;

    t_cmd_word   cmd_queue[$];
    t_report     expected_reports[$];
    t_cmd_word   drv_word;
    t_report     head_report;
    logic [31:0] clock_ms = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req = 0, hold_seen = 0, hold_left = 0;
    int words_taken = 0, reports_checked = 0, pings_seen = 0, mismatches = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic far_flag(input int s);
        return miss_q[s] >= {2'b00, thr_cfg};
    endfunction

    function automatic t_report report_of(input msps_pkg::t_kind k, input logic [1:0] s,
                                          input logic [1:0] st, input logic [15:0] d,
                                          input logic f);
        t_report r;
        r.kind    = k;
        r.sensor  = s;
        r.stopped = st;
        r.dist_mm = d;
        r.far     = f;
        r.fin     = 1'b0;
        return r;
    endfunction

    // Works out the result words of one accepted command word and updates the state.
    function automatic void predict_reports(input t_cmd_word w);
        t_report     batch [4];
        int          n;
        logic [31:0] step, mm;
        logic [7:0]  m;
        logic [1:0]  c, prev;
        n = 0;
        case (w.cmd)
            msps_pkg::CMD_START: begin
                due_q[0] = w.now + msps_pkg::START_DELAY_MS;
                for (int i = 1; i < SENSORS; i++) due_q[i] = due_q[i-1] + {16'd0, period_cfg};
                for (int i = 0; i < SENSORS; i++) miss_q[i] = '0;
                batch[n++] = report_of(msps_pkg::KIND_DONE, 2'd0, 2'd0, 16'd0, 1'b0);
            end
            msps_pkg::CMD_TICK: begin
                step = {14'd0, period_cfg, 2'b00};
                for (int i = 0; i < SENSORS; i++) begin
                    if (w.now >= due_q[i]) begin
                        prev     = cur_q;
                        due_q[i] = due_q[i] + step;
                        cur_q    = 2'(i);
                        if (n < 4) batch[n++] = report_of(msps_pkg::KIND_PING, 2'(i), prev,
                                                          range_q[i], far_flag(i));
                    end
                end
            end
            msps_pkg::CMD_ECHO: begin
                c = cur_q;
                if (w.echo) begin
                    if (rt_cfg == '0) begin
                        mm = 32'hFFFF;
                    end else begin
                        mm = ({16'd0, w.echo_us} * {12'd0, msps_pkg::MM_PER_CM})
                             / {24'd0, rt_cfg};
                        if (mm > 32'hFFFF) mm = 32'hFFFF;
                    end
                    range_q[c] = mm[15:0];
                    miss_q[c]  = '0;
                end else begin
                    m = miss_q[c] + 8'd1;
                    if (m >= {2'b00, thr_cfg}) begin
                        range_q[c] = maxd_cfg;
                        // Past twice the threshold the counter drops back to the threshold.
                        if ({1'b0, m} > {2'b00, thr_cfg, 1'b0}) m = {2'b00, thr_cfg};
                    end
                    miss_q[c] = m;
                end
                batch[n++] = report_of(msps_pkg::KIND_ECHO, c, 2'd0, range_q[c], far_flag(c));
            end
            default: begin
                if (int'(w.idx) < SENSORS)
                    batch[n++] = report_of(msps_pkg::KIND_QUERY, w.idx, 2'd0, range_q[w.idx],
                                           far_flag(int'(w.idx)));
                else
                    batch[n++] = report_of(msps_pkg::KIND_QUERY, w.idx, 2'd0, 16'd0, 1'b0);
            end
        endcase
        if (n > 0) batch[n-1].fin = 1'b1;
        for (int i = 0; i < n; i++) expected_reports.push_back(batch[i]);
    endfunction

    function automatic void check_field(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endfunction

    // Driver: a word stays on the port until it is taken.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_reports(drv_word);
                words_taken++;
            end
            if (!in_valid || o_in_ready) begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_word = cmd_queue.pop_front();
                    in_valid <= 1'b1;
                    cmd_drv  <= drv_word.cmd;
                    now_drv  <= drv_word.now;
                    echo_drv <= drv_word.echo;
                    us_drv   <= drv_word.echo_us;
                    idx_drv  <= drv_word.idx;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold whenever one is requested.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_reports.size() == 0) begin
                $error("result word with nothing expected: kind %0d sensor %0d", o_kind,
                       o_sensor);
                mismatches++;
            end else begin
                head_report = expected_reports.pop_front();
                check_field("kind", 32'(head_report.kind), 32'(o_kind));
                check_field("sensor", 32'(head_report.sensor), 32'(o_sensor));
                check_field("stopped_sensor", 32'(head_report.stopped),
                            32'(o_stopped_sensor));
                check_field("distance_mm", 32'(head_report.dist_mm), 32'(o_distance_mm));
                check_field("too_far", 32'(head_report.far), 32'(o_too_far));
                check_field("last", 32'(head_report.fin), 32'(o_last));
                reports_checked++;
                if (o_kind == msps_pkg::KIND_PING) pings_seen++;
            end
        end
    end

    task automatic write_reg(input logic [msps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            msps_pkg::REG_PERIOD:    period_cfg = val;
            msps_pkg::REG_MISS_THR:  thr_cfg    = val[5:0];
            msps_pkg::REG_MAX_DIST:  maxd_cfg   = val;
            msps_pkg::REG_ROUNDTRIP: rt_cfg     = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] period, input logic [15:0] thr,
                            input logic [15:0] maxd, input logic [15:0] rt);
        write_reg(msps_pkg::REG_PERIOD, period);
        write_reg(msps_pkg::REG_MISS_THR, thr);
        write_reg(msps_pkg::REG_MAX_DIST, maxd);
        write_reg(msps_pkg::REG_ROUNDTRIP, rt);
    endtask

    task automatic push_word(input msps_pkg::t_command cmd, input logic [31:0] now,
                             input logic echo, input logic [15:0] us, input logic [1:0] idx);
        t_cmd_word w;
        w.cmd     = cmd;
        w.now     = now;
        w.echo    = echo;
        w.echo_us = us;
        w.idx     = idx;
        cmd_queue.push_back(w);
    endtask

    // Mostly a running schedule with time moving forward; some ticks jump to any time.
    task automatic add_random(input int n);
        t_cmd_word w;
        int        sel;
        repeat (n) begin
            sel       = $urandom_range(99);
            w.now     = $urandom;
            w.echo    = 1'($urandom_range(1));
            w.echo_us = 16'($urandom);
            w.idx     = 2'($urandom_range(3));
            if (sel < 7) begin
                w.cmd = msps_pkg::CMD_START;
                case ($urandom_range(3))
                    0:       clock_ms = $urandom;
                    1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                    default: ;
                endcase
                w.now = clock_ms;
            end else if (sel < 45) begin
                w.cmd = msps_pkg::CMD_TICK;
                if ($urandom_range(9) != 0) begin
                    if ($urandom_range(4) == 0)
                        clock_ms = clock_ms + $urandom_range(0, 150);
                    else
                        clock_ms = clock_ms + $urandom_range(0, 2 * int'(period_cfg) + 1);
                    w.now = clock_ms;
                end
            end else if (sel < 80) begin
                w.cmd  = msps_pkg::CMD_ECHO;
                w.echo = ($urandom_range(99) < 45);
                case ($urandom_range(7))
                    0:       w.echo_us = 16'h0000;
                    1:       w.echo_us = 16'hFFFF;
                    default: ;
                endcase
            end else begin
                w.cmd = msps_pkg::CMD_QUERY;
            end
            cmd_queue.push_back(w);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // A tick with nothing due gives no word, so let the block settle after the last one.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < SENSORS; i++) begin
            due_q[i]   = '0;
            range_q[i] = '0;
            miss_q[i]  = '0;
        end
        cur_q = '0;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;

        // Reset settings: readings at reset, every sensor due at once, wrapped due times,
        // nothing due, and a run of misses past twice the threshold.
        @(negedge i_clk);
        set_idling(0, 0);
        for (int i = 0; i < SENSORS; i++)
            push_word(msps_pkg::CMD_QUERY, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 2'(i));
        push_word(msps_pkg::CMD_ECHO, 32'h0, 1'b1, 16'hFFFF, 2'd0);
        push_word(msps_pkg::CMD_TICK, 32'h0, 1'b0, 16'h0, 2'd0);
        push_word(msps_pkg::CMD_START, 32'hFFFF_FFC0, 1'b0, 16'h0, 2'd0);
        push_word(msps_pkg::CMD_TICK, 32'h0, 1'b0, 16'h0, 2'd0);
        push_word(msps_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b0, 16'h0, 2'd0);
        repeat (7) push_word(msps_pkg::CMD_ECHO, 32'h0, 1'b0, 16'h1234, 2'd0);
        push_word(msps_pkg::CMD_ECHO, 32'h0, 1'b1, 16'h0000, 2'd0);
        push_word(msps_pkg::CMD_QUERY, 32'h0, 1'b0, 16'h0, 2'd3);
        add_random(40);
        wait_idle();

        // Shortest period, widest threshold, largest reading and a divisor of one.
        set_regs(16'd1, 16'd63, 16'hFFFF, 16'd1);
        @(negedge i_clk);
        push_word(msps_pkg::CMD_START, 32'd1000, 1'b0, 16'h0, 2'd0);
        push_word(msps_pkg::CMD_ECHO, 32'h0, 1'b1, 16'hFFFF, 2'd0);
        push_word(msps_pkg::CMD_ECHO, 32'h0, 1'b1, 16'd6553, 2'd0);
        push_word(msps_pkg::CMD_TICK, 32'h0000_FFFF, 1'b0, 16'h0, 2'd0);
        clock_ms = 32'd1000;
        add_random(40);
        wait_idle();

        // Zero threshold and zero divisor, with the longest period and a zero reading.
        set_regs(16'hFFFF, 16'd0, 16'd0, 16'd0);
        @(negedge i_clk);
        set_idling(87, 0);
        push_word(msps_pkg::CMD_START, 32'h0, 1'b0, 16'h0, 2'd0);
        push_word(msps_pkg::CMD_ECHO, 32'h0, 1'b0, 16'h0, 2'd0);
        push_word(msps_pkg::CMD_ECHO, 32'h0, 1'b1, 16'd1234, 2'd0);
        push_word(msps_pkg::CMD_QUERY, 32'h0, 1'b0, 16'h0, 2'd3);
        clock_ms = 32'h0;
        add_random(40);
        wait_idle();

        set_regs(msps_pkg::PERIOD_RST, 16'(msps_pkg::MISS_THR_RST), msps_pkg::MAX_DIST_RST,
                 16'(msps_pkg::ROUNDTRIP_RST));
        @(negedge i_clk);
        set_idling(0, 87);
        hold_req++;
        add_random(50);
        wait_idle();

        set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 63)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(1, 255)));
        @(negedge i_clk);
        set_idling(12, 12);
        hold_req++;
        add_random(50);
        wait_idle();

        set_regs(16'($urandom_range(1, 200)), 16'd1, 16'($urandom_range(0, 65535)), 16'd255);
        @(negedge i_clk);
        set_idling(0, 0);
        add_random(20);
        wait_idle();

        $display("Checked %0d result words from %0d command words, %0d of them ping starts.",
                 reports_checked, words_taken, pings_seen);
        $display("Six register settings ran, from the range ends to a zero divisor and threshold,");
        $display("under sender gaps, receiver stalls and long output holds.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/msps_pkg.sv
sv/msps_div.sv
sv/msps_dp.sv
sv/msps_ctrl.sv
sv/multi_sonar_ping_scheduler_top.sv
tb/sv/multi_sonar_ping_scheduler_top_tb.sv
